[hw/rtl/pora_pkg.sv]
// ----------------------------------------------------------------------------
// pora_pkg
// shared types, codes and defaults of the path oram controller
// ----------------------------------------------------------------------------
package pora_pkg;

	localparam int DEF_NUM_BLOCKS   = 1024;
	localparam int DEF_LEVELS       = 10;
	localparam int DEF_BUCKET_SLOTS = 4;
	localparam int DEF_STASH_DEPTH  = 64;
	localparam int DEF_DATA_BITS    = 64;

	localparam int MODE_W = 2;
	localparam int ID_W   = 10;
	localparam int LEAF_W = 10;
	localparam int WORD_W = 64;

	localparam logic [MODE_W-1:0] MODE_READ  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PLACE = 2'd2;
	localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_PM_GOT,
		S_PL_RD,
		S_PL_DO,
		S_PATH_RD,
		S_PATH_PUSH,
		S_FIND_RD,
		S_FIND_CHK,
		S_FIND_END,
		S_EV_START,
		S_EV_RD,
		S_EV_PM,
		S_EV_CHK,
		S_EV_WR,
		S_FIN
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic latch_req;
		logic pm_rd_id;
		logic pm_got;
		logic place_rd;
		logic place_do;
		logic path_rd;
		logic path_push;
		logic find_rd;
		logic find_chk;
		logic find_end;
		logic ev_start;
		logic ev_rd;
		logic ev_pm;
		logic ev_chk;
		logic ev_wr;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic bad_req;
		logic is_place;
		logic last_slot;
		logic level_top;
		logic level_zero;
		logic r_end;
		logic id_hit;
		logic cnt_over;
	} stat_t;

endpackage

[hw/rtl/pora_ctrl.sv]
// ----------------------------------------------------------------------------
// pora_ctrl
// sequencer of the access: clear, path read, lookup, eviction or placement, result
// ----------------------------------------------------------------------------
module pora_ctrl
	import pora_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	input  stat_t st,
	output cmd_t  cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign in_ready  = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (st.clr_done)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch_req = 1'b1;
					state_d       = S_DECODE;
				end
			end
			S_DECODE: begin
				if (st.bad_req)
					state_d = S_FIN;
				else if (st.is_place)
					state_d = S_PL_RD;
				else begin
					cmd.pm_rd_id = 1'b1;
					state_d      = S_PM_GOT;
				end
			end
			S_PM_GOT: begin
				cmd.pm_got = 1'b1;
				state_d    = S_PATH_RD;
			end
			S_PL_RD: begin
				cmd.place_rd = 1'b1;
				state_d      = S_PL_DO;
			end
			S_PL_DO: begin
				cmd.place_do = 1'b1;
				state_d      = S_FIN;
			end
			S_PATH_RD: begin
				cmd.path_rd = 1'b1;
				state_d     = S_PATH_PUSH;
			end
			S_PATH_PUSH: begin
				cmd.path_push = 1'b1;
				if (st.last_slot)
					state_d = st.level_top ? S_FIND_RD : S_PATH_RD;
			end
			S_FIND_RD: begin
				cmd.find_rd = 1'b1;
				state_d     = st.r_end ? S_FIND_END : S_FIND_CHK;
			end
			S_FIND_CHK: begin
				cmd.find_chk = 1'b1;
				state_d      = st.id_hit ? S_FIND_END : S_FIND_RD;
			end
			S_FIND_END: begin
				cmd.find_end = 1'b1;
				state_d      = S_EV_START;
			end
			S_EV_START: begin
				cmd.ev_start = 1'b1;
				state_d      = S_EV_RD;
			end
			S_EV_RD: begin
				cmd.ev_rd = 1'b1;
				state_d   = st.r_end ? S_EV_WR : S_EV_PM;
			end
			S_EV_PM: begin
				cmd.ev_pm = 1'b1;
				state_d   = S_EV_CHK;
			end
			S_EV_CHK: begin
				cmd.ev_chk = 1'b1;
				state_d    = S_EV_RD;
			end
			S_EV_WR: begin
				cmd.ev_wr = 1'b1;
				state_d   = st.level_zero ? S_FIN : S_EV_START;
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

endmodule

[hw/rtl/pora_dp.sv]
// ----------------------------------------------------------------------------
// pora_dp
// position map, bucket tree and stash memories with their pointers
// ----------------------------------------------------------------------------
module pora_dp
	import pora_pkg::*;
#(
	parameter int NUM_BLOCKS   = DEF_NUM_BLOCKS,
	parameter int LEVELS       = DEF_LEVELS,
	parameter int BUCKET_SLOTS = DEF_BUCKET_SLOTS,
	parameter int STASH_DEPTH  = DEF_STASH_DEPTH,
	parameter int DATA_BITS    = DEF_DATA_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output stat_t             st,
	input  logic [MODE_W-1:0] mode,
	input  logic [ID_W-1:0]   blk_num,
	input  logic [LEAF_W-1:0] remap_leaf,
	input  logic [WORD_W-1:0] write_data,
	output logic [WORD_W-1:0] read_data,
	output logic              found,
	output logic              status
);

	localparam int TREE_NODES = (2 ** (LEVELS + 1)) - 1;
	localparam int TAW   = LEVELS + 1;
	localparam int PM_AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int CLR_N = (TREE_NODES > NUM_BLOCKS) ? TREE_NODES : NUM_BLOCKS;
	localparam int CW    = $clog2(CLR_N + 1);
	localparam int SAW   = $clog2(STASH_DEPTH);
	localparam int SCW   = $clog2(STASH_DEPTH + 1);
	localparam int SLW   = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
	localparam int FW    = $clog2(BUCKET_SLOTS + 1);
	localparam int LVW   = $clog2(LEVELS + 1);
	localparam int RBW   = BUCKET_SLOTS * ID_W;
	localparam int RDW   = BUCKET_SLOTS * DATA_BITS;

	// memories
	logic [LEVELS-1:0]       pm_mem [NUM_BLOCKS];
	logic [BUCKET_SLOTS-1:0] tv_mem [TREE_NODES];
	logic [RBW-1:0]          tb_mem [TREE_NODES];
	logic [RDW-1:0]          td_mem [TREE_NODES];
	logic [ID_W-1:0]         sb_mem [STASH_DEPTH];
	logic [DATA_BITS-1:0]    sd_mem [STASH_DEPTH];

	// request and working registers
	logic [MODE_W-1:0]       mode_q;
	logic [ID_W-1:0]         id_q;
	logic [LEVELS-1:0]       leaf_q, x_q;
	logic [DATA_BITS-1:0]    wdata_q, rdata_q;
	logic                    found_q, drop_q;
	logic [SAW-1:0]          hit_q;
	logic [LVW-1:0]          level_q;
	logic [FW-1:0]           slot_q, fill_q;
	logic [SCW-1:0]          r_q, w_q, count_q;
	logic [CW-1:0]           clr_q;
	logic [BUCKET_SLOTS-1:0] rowv_q;
	logic [RBW-1:0]          rowb_q;
	logic [RDW-1:0]          rowd_q;
	logic [WORD_W-1:0]       read_data_q;
	logic                    found_out_q, status_q;

	// memory ports
	logic                    pm_we, pm_re;
	logic [PM_AW-1:0]        pm_wa, pm_ra;
	logic [LEVELS-1:0]       pm_wd, pm_rd;
	logic                    tv_we, tbd_we, t_re;
	logic [TAW-1:0]          t_wa, t_ra;
	logic [BUCKET_SLOTS-1:0] tv_wd, tv_rd;
	logic [RBW-1:0]          tb_wd, tb_rd;
	logic [RDW-1:0]          td_wd, td_rd;
	logic                    s_we, s_re;
	logic [SAW-1:0]          s_wa;
	logic [ID_W-1:0]         sb_wd, sb_rd;
	logic [DATA_BITS-1:0]    sd_wd, sd_rd;

	logic                    full, slot_v, match, has_free, push_ok;
	logic [SLW-1:0]          fsel;
	logic [TAW-1:0]          path_node, place_node;

	function automatic logic [TAW-1:0] node_addr(input logic [LEVELS-1:0] lf,
		input logic [LVW-1:0] lvl);
		logic [TAW-1:0] n;
		n = {1'b1, lf} >> (LEVELS - int'(lvl));
		return n - TAW'(1);
	endfunction

	assign full       = (count_q >= SCW'(STASH_DEPTH));
	assign path_node  = node_addr(x_q, level_q);
	assign place_node = node_addr(leaf_q, LVW'(LEVELS));
	assign slot_v     = tv_rd[slot_q[SLW-1:0]];
	assign match      = (fill_q != FW'(BUCKET_SLOTS))
		&& (((pm_rd ^ x_q) >> (LEVELS - int'(level_q))) == '0);

	// first free slot of the leaf bucket for placement
	always_comb begin
		has_free = 1'b0;
		fsel     = '0;
		for (int i = BUCKET_SLOTS - 1; i >= 0; i--) begin
			if (!tv_rd[i]) begin
				has_free = 1'b1;
				fsel     = SLW'(i);
			end
		end
	end

	// port selection
	always_comb begin
		pm_we  = 1'b0;
		pm_wa  = PM_AW'(id_q);
		pm_wd  = leaf_q;
		pm_re  = cmd.pm_rd_id | cmd.ev_pm;
		pm_ra  = cmd.ev_pm ? PM_AW'(sb_rd) : PM_AW'(id_q);
		tv_we  = 1'b0;
		tbd_we = 1'b0;
		t_wa   = path_node;
		tv_wd  = rowv_q;
		tb_wd  = rowb_q;
		td_wd  = rowd_q;
		t_re   = cmd.path_rd | cmd.place_rd;
		t_ra   = cmd.place_rd ? place_node : path_node;
		s_we   = 1'b0;
		s_wa   = count_q[SAW-1:0];
		sb_wd  = id_q;
		sd_wd  = wdata_q;
		s_re   = (cmd.find_rd | cmd.ev_rd) & (r_q < count_q);
		push_ok = 1'b0;
		if (cmd.clr_step) begin
			pm_we = (32'(clr_q) < NUM_BLOCKS);
			pm_wa = PM_AW'(clr_q);
			pm_wd = '0;
			tv_we = (32'(clr_q) < TREE_NODES);
			t_wa  = TAW'(clr_q);
			tv_wd = '0;
		end
		if (cmd.place_rd || cmd.pm_got)
			pm_we = 1'b1;
		if (cmd.place_do && has_free) begin
			tv_we  = 1'b1;
			tbd_we = 1'b1;
			t_wa   = place_node;
			tv_wd  = tv_rd;
			tv_wd[fsel] = 1'b1;
			tb_wd  = tb_rd;
			tb_wd[fsel*ID_W +: ID_W] = id_q;
			td_wd  = td_rd;
			td_wd[fsel*DATA_BITS +: DATA_BITS] = wdata_q;
		end
		if (cmd.ev_wr) begin
			tv_we  = 1'b1;
			tbd_we = 1'b1;
		end
		if (cmd.path_push && slot_v && !full) begin
			s_we    = 1'b1;
			push_ok = 1'b1;
			sb_wd   = tb_rd[slot_q*ID_W +: ID_W];
			sd_wd   = td_rd[slot_q*DATA_BITS +: DATA_BITS];
		end
		if (cmd.place_do && !has_free && !full) begin
			s_we    = 1'b1;
			push_ok = 1'b1;
		end
		if (cmd.find_end && mode_q == MODE_WRITE) begin
			if (found_q) begin
				s_we = 1'b1;
				s_wa = hit_q;
			end else if (!full) begin
				s_we    = 1'b1;
				push_ok = 1'b1;
			end
		end
		if (cmd.ev_chk && !match) begin
			s_we  = 1'b1;
			s_wa  = w_q[SAW-1:0];
			sb_wd = sb_rd;
			sd_wd = sd_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (pm_we)
			pm_mem[pm_wa] <= pm_wd;
		if (pm_re)
			pm_rd <= pm_mem[pm_ra];
	end

	always_ff @(posedge clk) begin
		if (tv_we)
			tv_mem[t_wa] <= tv_wd;
		if (tbd_we) begin
			tb_mem[t_wa] <= tb_wd;
			td_mem[t_wa] <= td_wd;
		end
		if (t_re) begin
			tv_rd <= tv_mem[t_ra];
			tb_rd <= tb_mem[t_ra];
			td_rd <= td_mem[t_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (s_we) begin
			sb_mem[s_wa] <= sb_wd;
			sd_mem[s_wa] <= sd_wd;
		end
		if (s_re) begin
			sb_rd <= sb_mem[r_q[SAW-1:0]];
			sd_rd <= sd_mem[r_q[SAW-1:0]];
		end
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			count_q <= '0;
		end else begin
			if (cmd.clr_step)
				clr_q <= clr_q + CW'(1);
			if (push_ok)
				count_q <= count_q + SCW'(1);
			else if (cmd.ev_wr)
				count_q <= w_q;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.latch_req) begin
			mode_q  <= mode;
			id_q    <= blk_num;
			leaf_q  <= LEVELS'(remap_leaf);
			wdata_q <= DATA_BITS'(write_data);
			rdata_q <= '0;
			found_q <= 1'b0;
			drop_q  <= 1'b0;
		end
		if (cmd.pm_got) begin
			x_q     <= pm_rd;
			level_q <= '0;
		end
		if (cmd.path_rd)
			slot_q <= '0;
		if (cmd.path_push) begin
			slot_q <= slot_q + FW'(1);
			if (slot_v && full)
				drop_q <= 1'b1;
			if (slot_q == FW'(BUCKET_SLOTS - 1)) begin
				level_q <= level_q + LVW'(1);
				r_q     <= '0;
			end
		end
		if (cmd.place_do && !has_free && full)
			drop_q <= 1'b1;
		if (cmd.find_chk) begin
			if (sb_rd == id_q) begin
				found_q <= 1'b1;
				hit_q   <= r_q[SAW-1:0];
				rdata_q <= sd_rd;
			end else
				r_q <= r_q + SCW'(1);
		end
		if (cmd.find_end) begin
			level_q <= LVW'(LEVELS);
			if (mode_q == MODE_WRITE && !found_q && full)
				drop_q <= 1'b1;
		end
		if (cmd.ev_start) begin
			r_q    <= '0;
			w_q    <= '0;
			fill_q <= '0;
			rowv_q <= '0;
		end
		if (cmd.ev_chk) begin
			r_q <= r_q + SCW'(1);
			if (match) begin
				rowv_q[fill_q[SLW-1:0]] <= 1'b1;
				rowb_q[fill_q*ID_W +: ID_W] <= sb_rd;
				rowd_q[fill_q*DATA_BITS +: DATA_BITS] <= sd_rd;
				fill_q <= fill_q + FW'(1);
			end else
				w_q <= w_q + SCW'(1);
		end
		if (cmd.ev_wr)
			level_q <= level_q - LVW'(1);
		if (cmd.load_out) begin
			read_data_q <= WORD_W'(rdata_q);
			found_out_q <= found_q;
			status_q    <= drop_q;
		end
	end

	assign read_data = read_data_q;
	assign found     = found_out_q;
	assign status    = status_q;

	always_comb begin
		st            = '0;
		st.clr_done   = (clr_q == CW'(CLR_N - 1));
		st.bad_req    = (mode_q == MODE_NONE) || (32'(id_q) >= NUM_BLOCKS);
		st.is_place   = (mode_q == MODE_PLACE);
		st.last_slot  = (slot_q == FW'(BUCKET_SLOTS - 1));
		st.level_top  = (level_q == LVW'(LEVELS));
		st.level_zero = (level_q == '0);
		st.r_end      = (r_q >= count_q);
		st.id_hit     = (sb_rd == id_q);
		st.cnt_over   = (count_q > SCW'(STASH_DEPTH));
	end

endmodule

[hw/rtl/path_oram_access_controller_unit.sv]
// ----------------------------------------------------------------------------
// path_oram_access_controller_unit
// path oram controller: position map, bucket tree and stash with eviction
// ----------------------------------------------------------------------------
// One request at a time. After reset a clearing pass writes the position map
// and the bucket valid rows, with in_ready low. A read or write request then
// pulls the path into the stash, looks the block up in the stash, and runs a
// greedy eviction in which each level scans the stash once, taking each entry
// through a stash read, a position map read and a keep or move decision in
// the stash and position map memories, and finally loads the result.
// A placement reads the leaf bucket and writes the block into its first free
// slot, or into the stash if the bucket is full; an ignored request goes
// straight to the result. The result sits in an output register, so the next
// request may be taken while it waits.
// ----------------------------------------------------------------------------
module path_oram_access_controller_unit
	import pora_pkg::*;
#(
	parameter int NUM_BLOCKS   = DEF_NUM_BLOCKS,
	parameter int LEVELS       = DEF_LEVELS,
	parameter int BUCKET_SLOTS = DEF_BUCKET_SLOTS,
	parameter int STASH_DEPTH  = DEF_STASH_DEPTH,
	parameter int DATA_BITS    = DEF_DATA_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	// request channel
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [MODE_W-1:0] mode,
	input  logic [ID_W-1:0]   blk_num,
	input  logic [LEAF_W-1:0] remap_leaf,
	input  logic [WORD_W-1:0] write_data,
	// result channel
	output logic              out_valid,
	input  logic              out_ready,
	output logic [WORD_W-1:0] read_data,
	output logic              found,
	output logic              status
);

	cmd_t  cmd;
	stat_t st;

	// sequencer
	pora_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	// memories and working registers
	pora_dp #(
		.NUM_BLOCKS   (NUM_BLOCKS),
		.LEVELS       (LEVELS),
		.BUCKET_SLOTS (BUCKET_SLOTS),
		.STASH_DEPTH  (STASH_DEPTH),
		.DATA_BITS    (DATA_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.mode       (mode),
		.blk_num    (blk_num),
		.remap_leaf (remap_leaf),
		.write_data (write_data),
		.read_data  (read_data),
		.found      (found),
		.status     (status)
	);

	// a taken request keeps the block busy for at least the next cycle
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request taken while previous one in flight");

	// a result only shows up when the sequencer loads it
	a_out_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.load_out))
		else $error("result valid without a load");

	// stash fill never passes its depth
	a_stash_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!st.cnt_over)
		else $error("stash count beyond depth");

endmodule

[bench/path_oram_access_controller_unit_tb.sv]
// ----------------------------------------------------------------------------
// path_oram_access_controller_unit_tb
// self-checking bench: directed table, then random requests against a model
// of the bucket tree, position map and stash, with stalls on both channels
// ----------------------------------------------------------------------------
module path_oram_access_controller_unit_tb
	import pora_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NBLK   = DEF_NUM_BLOCKS;
	localparam int LVLS   = DEF_LEVELS;
	localparam int SLOTS  = DEF_BUCKET_SLOTS;
	localparam int SDEPTH = DEF_STASH_DEPTH;
	localparam int NLEAF  = 1 << LVLS;
	localparam int NNODE  = (2 << LVLS) - 1;
	localparam int NTREE  = NNODE * SLOTS;
	// watchdog limit outlasts the clearing pass, a full-stash request and long stalls
	localparam int WATCHDOG_LIMIT = 30000;
	localparam int RANDOM_ITEMS   = 650;

	typedef struct packed {
		logic [WORD_W-1:0] data;
		logic              hit;
		logic              drop;
	} oram_result_t;

	typedef struct {
		logic [MODE_W-1:0] md;
		logic [ID_W-1:0]   id;
		logic [LEAF_W-1:0] lf;
		logic [WORD_W-1:0] wd;
		bit                typed;
		oram_result_t      want;
	} table_row_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [MODE_W-1:0] mode;
	logic [ID_W-1:0]   blk_num;
	logic [LEAF_W-1:0] remap_leaf;
	logic [WORD_W-1:0] write_data;
	logic              out_valid;
	logic              out_ready;
	logic [WORD_W-1:0] read_data;
	logic              found;
	logic              status;

	path_oram_access_controller_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .blk_num(blk_num), .remap_leaf(remap_leaf), .write_data(write_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.read_data(read_data), .found(found), .status(status)
	);

	// model state
	int unsigned       pos_map [NBLK];
	bit                tree_vld [NTREE];
	int unsigned       tree_id [NTREE];
	logic [WORD_W-1:0] tree_word [NTREE];
	int unsigned       stash_id [SDEPTH];
	logic [WORD_W-1:0] stash_word [SDEPTH];
	int unsigned       stash_cnt;

	oram_result_t pending_results [$];
	int           mismatch_count = 0;
	int           idle_cycles = 0;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// bucket on the path to a leaf at a given depth (root is level 0)
	function automatic int unsigned path_node(int unsigned lf, int unsigned lvl);
		return (NLEAF + (lf % NLEAF)) >> (LVLS - lvl);
	endfunction

	function automatic bit stash_append(int unsigned id, logic [WORD_W-1:0] w);
		if (stash_cnt >= SDEPTH)
			return 1'b0;
		stash_id[stash_cnt]   = id;
		stash_word[stash_cnt] = w;
		stash_cnt++;
		return 1'b1;
	endfunction

	// advance the model by one request and return its result
	function automatic oram_result_t oram_access(logic [MODE_W-1:0] md, logic [ID_W-1:0] id,
			logic [LEAF_W-1:0] lf_in, logic [WORD_W-1:0] wd);
		oram_result_t r;
		int unsigned lf, base, x, hit_at, tgt, fill, j, b, k;
		bit placed;
		r = '0;
		lf = lf_in % NLEAF;
		if (md == MODE_NONE || id >= NBLK)
			return r;
		if (md == MODE_PLACE) begin
			base = (path_node(lf, LVLS) - 1) * SLOTS;
			placed = 1'b0;
			pos_map[id] = lf;
			for (int i = 0; i < SLOTS && !placed; i++) begin
				if (!tree_vld[base + i]) begin
					tree_vld[base + i]  = 1'b1;
					tree_id[base + i]   = id;
					tree_word[base + i] = wd;
					placed = 1'b1;
				end
			end
			if (!placed && !stash_append(id, wd))
				r.drop = 1'b1;
			return r;
		end
		x = pos_map[id];
		pos_map[id] = lf;
		// pull the old path into the stash
		for (int lvl = 0; lvl <= LVLS; lvl++) begin
			base = (path_node(x, lvl) - 1) * SLOTS;
			for (int i = 0; i < SLOTS; i++) begin
				if (tree_vld[base + i]) begin
					if (!stash_append(tree_id[base + i], tree_word[base + i]))
						r.drop = 1'b1;
					tree_vld[base + i] = 1'b0;
				end
			end
		end
		hit_at = 0;
		for (int i = 0; i < stash_cnt && !r.hit; i++) begin
			if (stash_id[i] == id) begin
				r.hit  = 1'b1;
				hit_at = i;
				r.data = stash_word[i];
			end
		end
		if (md == MODE_WRITE) begin
			if (r.hit)
				stash_word[hit_at] = wd;
			else if (!stash_append(id, wd))
				r.drop = 1'b1;
		end
		// greedy refill from leaf to root
		for (int lvl = LVLS; lvl >= 0; lvl--) begin
			tgt  = path_node(x, lvl);
			base = (tgt - 1) * SLOTS;
			fill = 0;
			j = 0;
			while (j < stash_cnt && fill < SLOTS) begin
				b = stash_id[j];
				if (b < NBLK && path_node(pos_map[b], lvl) == tgt) begin
					tree_vld[base + fill]  = 1'b1;
					tree_id[base + fill]   = b;
					tree_word[base + fill] = stash_word[j];
					fill++;
					for (k = j; k + 1 < stash_cnt; k++) begin
						stash_id[k]   = stash_id[k + 1];
						stash_word[k] = stash_word[k + 1];
					end
					stash_cnt--;
				end else begin
					j++;
				end
			end
		end
		return r;
	endfunction

	function automatic int gap_len();
		int p;
		p = $urandom_range(99);
		if (p < 65)
			return 0;
		if (p < 93)
			return $urandom_range(1, 3);
		return $urandom_range(20, 80);
	endfunction

	// drive one request and wait for it to be taken; the model steps at acceptance
	task automatic send_request(logic [MODE_W-1:0] md, logic [ID_W-1:0] id,
			logic [LEAF_W-1:0] lf, logic [WORD_W-1:0] wd, bit typed, oram_result_t want);
		int g;
		oram_result_t r;
		bit taken;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		in_valid   <= 1'b1;
		mode       <= md;
		blk_num    <= id;
		remap_leaf <= lf;
		write_data <= wd;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = in_valid && in_ready;
		end
		r = oram_access(md, id, lf, wd);
		pending_results = {pending_results, (typed ? want : r)};
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	// result stalls: bursts of ready, gaps mostly short, now and then long
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 40)) @(negedge clk);
			out_ready <= 1'b0;
			repeat ($urandom_range(1, 2) + (($urandom_range(9) == 0) ? 60 : 0)) @(negedge clk);
		end
	end

	// result checker
	always @(posedge clk) begin
		oram_result_t w;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: read_data %h found %b status %b",
					read_data, found, status);
				mismatch_count++;
			end else begin
				w = pending_results.pop_front();
				if (read_data !== w.data) begin
					$error("read_data expected %h actual %h", w.data, read_data);
					mismatch_count++;
				end
				if (found !== w.hit) begin
					$error("found expected %b actual %b", w.hit, found);
					mismatch_count++;
				end
				if (status !== w.drop) begin
					$error("status expected %b actual %b", w.drop, status);
					mismatch_count++;
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	localparam logic [WORD_W-1:0] ONES = {WORD_W{1'b1}};
	localparam logic [WORD_W-1:0] AAAA = 64'hA5A5_A5A5_A5A5_A5A5;

	table_row_t directed [] = '{
		// fresh tree: nothing there
		'{MODE_READ,  10'd0,    10'd5,    64'd0, 1'b1, '{64'd0, 1'b0, 1'b0}},
		'{MODE_WRITE, 10'd0,    10'd1023, ONES,  1'b1, '{64'd0, 1'b0, 1'b0}},
		'{MODE_READ,  10'd0,    10'd0,    64'd0, 1'b1, '{ONES,  1'b1, 1'b0}},
		'{MODE_WRITE, 10'd1023, 10'd0,    64'd0, 1'b1, '{64'd0, 1'b0, 1'b0}},
		'{MODE_WRITE, 10'd1023, 10'd512,  AAAA,  1'b1, '{64'd0, 1'b1, 1'b0}},
		'{MODE_READ,  10'd1023, 10'd1023, 64'd0, 1'b1, '{AAAA,  1'b1, 1'b0}},
		// unused mode is ignored
		'{MODE_NONE,  10'd1023, 10'd1023, ONES,  1'b1, '{64'd0, 1'b0, 1'b0}},
		// placement reports nothing; second placement makes a duplicate copy
		'{MODE_PLACE, 10'd7,    10'd1023, 64'h1234, 1'b1, '{64'd0, 1'b0, 1'b0}},
		'{MODE_PLACE, 10'd7,    10'd1023, 64'h5678, 1'b1, '{64'd0, 1'b0, 1'b0}},
		'{MODE_READ,  10'd7,    10'd3,    64'd0, 1'b0, '0},
		'{MODE_READ,  10'd7,    10'd3,    64'd0, 1'b0, '0},
		'{MODE_WRITE, 10'd512,  10'd341,  64'h5555_5555_5555_5555, 1'b0, '0},
		'{MODE_READ,  10'd512,  10'd682,  64'd0, 1'b0, '0},
		// overfill one leaf bucket so placements spill into the stash
		'{MODE_PLACE, 10'd100,  10'd0,    64'd100, 1'b0, '0},
		'{MODE_PLACE, 10'd101,  10'd0,    64'd101, 1'b0, '0},
		'{MODE_PLACE, 10'd102,  10'd0,    64'd102, 1'b0, '0},
		'{MODE_PLACE, 10'd103,  10'd0,    64'd103, 1'b0, '0},
		'{MODE_PLACE, 10'd104,  10'd0,    64'd104, 1'b0, '0},
		'{MODE_PLACE, 10'd105,  10'd0,    64'd105, 1'b0, '0},
		'{MODE_READ,  10'd100,  10'd1023, 64'd0, 1'b0, '0},
		'{MODE_WRITE, 10'd105,  10'd0,    ONES,  1'b0, '0}
	};

	initial begin
		logic [ID_W-1:0]   working_set [24];
		logic [MODE_W-1:0] md;
		logic [ID_W-1:0]   id;
		logic [WORD_W-1:0] wd;
		int                p;
		int unsigned       flood_leaf;

		in_valid   = 1'b0;
		mode       = MODE_READ;
		blk_num    = '0;
		remap_leaf = '0;
		write_data = '0;
		arst_n     = 1'b0;
		for (int i = 0; i < NBLK; i++)
			pos_map[i] = 0;
		for (int i = 0; i < NTREE; i++)
			tree_vld[i] = 1'b0;
		stash_cnt = 0;

		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i])
			send_request(directed[i].md, directed[i].id, directed[i].lf, directed[i].wd,
				directed[i].typed, directed[i].want);

		for (int i = 0; i < 24; i++)
			working_set[i] = ID_W'($urandom_range(NBLK - 1));

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 2) begin
				// flood one leaf with placements until the stash overflows, then drain
				drain_results();
				flood_leaf = $urandom_range(NLEAF - 1);
				for (int k = 0; k < SDEPTH + SLOTS + 6; k++)
					send_request(MODE_PLACE, 10'(200 + k), 10'(flood_leaf),
						{$urandom, $urandom}, 1'b0, '0);
				for (int k = 0; k < 6; k++)
					send_request(MODE_READ, 10'(200 + 8 * k), 10'($urandom_range(NLEAF - 1)),
						'0, 1'b0, '0);
				drain_results();
			end
			p = $urandom_range(99);
			wd = {$urandom, $urandom};
			if (p < 45) begin
				md = MODE_WRITE;
				id = working_set[$urandom_range(23)];
			end else if (p < 85) begin
				md = MODE_READ;
				id = working_set[$urandom_range(23)];
			end else if (p < 91) begin
				md = MODE_PLACE;
				id = working_set[$urandom_range(23)];
			end else if (p < 95) begin
				md = MODE_NONE;
				id = ID_W'($urandom_range(NBLK - 1));
			end else begin
				md = $urandom_range(1) ? MODE_WRITE : MODE_READ;
				id = ID_W'($urandom_range(NBLK - 1));
			end
			send_request(md, id, 10'($urandom_range(NLEAF - 1)), wd, 1'b0, '0);
		end

		drain_results();
		// let a stray extra result show up
		repeat (200) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
